>>> hw/rtl/pls_pkg.sv
// Shared types and constants of the packet layer slicer.
package pls_pkg;

	localparam int MAX_FRAME_BYTES = 16384;
	localparam int MAX_LAYERS      = 8;

	localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
	localparam int POS_W  = $clog2(MAX_FRAME_BYTES);
	localparam int AW     = 16;
	localparam int OFF_W  = 14;
	localparam int LEN_W  = 15;
	localparam int ML_W   = 4;
	localparam int LIST_W = $clog2(MAX_LAYERS + 1);
	localparam int SEL_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam int ETH_HDR = 14;
	localparam int IP_HDR  = 20;
	localparam int TCP_HDR = 20;
	localparam int UDP_HDR = 8;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [3:0]  IHL_MIN        = 4'd5;

	localparam logic REG_START_LAYER = 1'b0;
	localparam logic REG_MAX_LAYERS  = 1'b1;

	typedef enum logic [2:0] {
		LT_ETH, LT_IP, LT_IPOPT, LT_TCP, LT_TCPOPT, LT_UDP, LT_PAYLOAD, LT_JUNK
	} layer_type_t;

	typedef struct packed {
		layer_type_t        ltype;
		logic [OFF_W-1:0]   offset;
		logic [LEN_W-1:0]   length;
		logic               damaged;
		logic               truncated;
		logic               final_layer;
		logic               unsupported;
		logic               no_layer;
	} desc_t;

	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [15:0]      ether_kind;
		logic [3:0]       ihl;
		logic [15:0]      frag;
		logic [15:0]      total_len;
		logic [7:0]       proto;
		logic [3:0]       doff;
		logic [15:0]      ulen;
		logic [3:0]       alt_doff;
		logic [15:0]      alt_ulen;
	} frame_t;

endpackage

>>> hw/rtl/pls_slicer.sv
// Frame slicer: turns one frame summary into its ordered layer descriptor list.
module pls_slicer (
	input  pls_pkg::frame_t                       frm,
	input  logic                                  start_layer,
	input  logic [pls_pkg::ML_W-1:0]              max_layers,
	output pls_pkg::desc_t [pls_pkg::MAX_LAYERS-1:0] list,
	output logic [pls_pkg::LIST_W-1:0]            count
);
	import pls_pkg::*;

	localparam int NSLOT  = 6;
	localparam int SLOT_W = $clog2(NSLOT + 1);

	logic            eth, have_eth, ip_go, ip_ok, ihl_bad, frag_bad;
	logic            len_over, alt, ip_dmg;
	logic [AW-1:0]   n, base, pk, lim, opt, hdr, t, tl;
	logic [5:0]      opt_raw;
	logic [3:0]      doff, eff;
	logic [AW-1:0]   ulen, d4, e4, to_len, rem, hl, pay, junk;
	logic            tcp_go, udp_go, t_over, t_dm, u_over;
	logic [LIST_W-1:0] cap;
	logic [SLOT_W-1:0] idx;
	desc_t [NSLOT-1:0] slot;
	logic  [NSLOT-1:0] en;
	desc_t             blank;

	function automatic desc_t mk(layer_type_t ty, logic [AW-1:0] off, logic [AW-1:0] len,
		logic dm, logic tr, logic fin, logic un);
		desc_t d;
		d.ltype       = ty;
		d.offset      = off[OFF_W-1:0];
		d.length      = len[LEN_W-1:0];
		d.damaged     = dm;
		d.truncated   = tr;
		d.final_layer = fin;
		d.unsupported = un;
		d.no_layer    = 1'b0;
		return d;
	endfunction

	always_comb begin
		eth      = !start_layer;
		base     = eth ? AW'(ETH_HDR) : '0;
		n        = AW'(frm.n);
		pk       = n - base;
		have_eth = eth && (n >= AW'(ETH_HDR));
		ip_go    = (!eth || (have_eth && frm.ether_kind == ETHERTYPE_IPV4))
			&& (n >= base + AW'(IP_HDR));
		ihl_bad  = frm.ihl < IHL_MIN;
		frag_bad = |frm.frag[12:0];
		ip_ok    = ip_go && !ihl_bad && !frag_bad;

		len_over = frm.total_len > pk;
		lim      = len_over ? pk : frm.total_len;
		opt_raw  = {frm.ihl - IHL_MIN, 2'b00};
		alt      = (AW'(opt_raw) + AW'(IP_HDR)) > pk;
		opt      = alt ? '0 : AW'(opt_raw);
		ip_dmg   = ihl_bad || (!frag_bad && (len_over || alt));

		hdr  = AW'(IP_HDR) + opt;
		t    = base + hdr;
		tl   = (lim >= hdr) ? lim - hdr : '0;
		doff = alt ? frm.alt_doff : frm.doff;
		ulen = alt ? frm.alt_ulen : frm.ulen;

		// tcp
		tcp_go = ip_ok && frm.proto == PROTO_TCP && tl >= AW'(TCP_HDR);
		d4     = AW'({doff, 2'b00});
		t_over = (doff != 4'd0) && (d4 > tl);
		t_dm   = t_over || ((doff != 4'd0) && (doff < IHL_MIN));
		eff    = t_over ? 4'd0 : ((doff != 4'd0 && doff < IHL_MIN) ? IHL_MIN : doff);
		e4     = AW'({eff, 2'b00});
		to_len = (eff != 4'd0) ? e4 - AW'(TCP_HDR) : tl - AW'(TCP_HDR);
		rem    = (eff != 4'd0) ? tl - e4 : '0;

		// udp
		udp_go = ip_ok && frm.proto == PROTO_UDP && tl >= AW'(UDP_HDR);
		u_over = ulen > tl;
		hl     = (ulen < AW'(UDP_HDR)) ? AW'(UDP_HDR) : ulen;
		pay    = u_over ? tl - AW'(UDP_HDR) : hl - AW'(UDP_HDR);
		junk   = u_over ? '0 : tl - hl;

		slot[0] = mk(LT_ETH, '0, AW'(ETH_HDR), 1'b0, 1'b0, 1'b0, 1'b0);
		en[0]   = have_eth;
		slot[1] = mk(LT_IP, base, AW'(IP_HDR), ip_dmg, 1'b0, ihl_bad || frag_bad,
			!ihl_bad && frag_bad);
		en[1]   = ip_go;
		slot[2] = mk(LT_IPOPT, base + AW'(IP_HDR), opt, 1'b0, 1'b0, 1'b0, 1'b0);
		en[2]   = ip_ok && opt != '0;
		if (tcp_go) begin
			slot[3] = mk(LT_TCP, t, AW'(TCP_HDR), t_dm, t_over, 1'b0, 1'b0);
			slot[4] = mk(LT_TCPOPT, t + AW'(TCP_HDR), to_len, 1'b0, 1'b0, 1'b0, 1'b0);
			slot[5] = mk(LT_PAYLOAD, t + AW'(TCP_HDR) + to_len, rem, 1'b0, 1'b0, 1'b0, 1'b0);
			en[3]   = 1'b1;
			en[4]   = to_len != '0;
			en[5]   = rem != '0;
		end else begin
			slot[3] = mk(LT_UDP, t, AW'(UDP_HDR), u_over, 1'b0, 1'b0, 1'b0);
			slot[4] = mk(LT_PAYLOAD, t + AW'(UDP_HDR), pay, 1'b0, 1'b0, 1'b0, 1'b0);
			slot[5] = mk(LT_JUNK, t + AW'(UDP_HDR) + pay, junk, 1'b0, 1'b0, 1'b0, 1'b0);
			en[3]   = udp_go;
			en[4]   = udp_go && pay != '0;
			en[5]   = udp_go && junk != '0;
		end

		blank          = '0;
		blank.no_layer = 1'b1;
		list           = '{default: '0};
		idx            = '0;
		for (int k = 0; k < NSLOT; k++) begin
			if (en[k] && int'(idx) < MAX_LAYERS) begin
				list[idx[SEL_W-1:0]] = slot[k];
				idx = idx + 1'b1;
			end
		end

		if (max_layers == '0)
			cap = LIST_W'(1);
		else if (int'(max_layers) > MAX_LAYERS)
			cap = LIST_W'(MAX_LAYERS);
		else
			cap = LIST_W'(max_layers);

		if (idx == '0) begin
			list[0] = blank;
			count   = LIST_W'(1);
		end else if (LIST_W'(idx) > cap) begin
			count = cap;
		end else begin
			count = LIST_W'(idx);
		end
	end

endmodule

>>> hw/rtl/packet_layer_slicer_core.sv
// Top level of the packet layer slicer: byte capture, frame hand-off and descriptor drain.
//
// Frames enter one byte per cycle while in_stall is low, and bytes are still taken while
// descriptors of earlier frames drain. Bytes pass an input register, then a capture stage
// that keeps the count and header fields; the last byte hands a frame summary to the
// slicer, whose descriptor list is registered and sent one descriptor per cycle while
// out_stall is low, the first one after the last byte has passed the input, summary and
// list registers. A frame's last byte waits in the input register, with further input
// held off (in_stall), only while the previous summary still waits for the descriptor
// list to empty, which happens when frames shorter than the previous frame's descriptor
// count follow one another or when the output is stalled. start_layer and max_layers sit
// at byte addresses 0 and 4 of the register port.
module packet_layer_slicer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pls_pkg::ADDR_W-1:0]    paddr,
	input  logic [pls_pkg::DATA_W-1:0]    pwdata,
	output logic [pls_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    layer_type,
	output logic [pls_pkg::OFF_W-1:0]     layer_offset,
	output logic [pls_pkg::LEN_W-1:0]     layer_length,
	output logic                          damaged,
	output logic                          truncated,
	output logic                          final_layer,
	output logic                          unsupported,
	output logic                          no_layer,
	output logic                          last_of_run
);
	import pls_pkg::*;

	logic                 start_layer_q;
	logic [ML_W-1:0]      max_layers_q;

	logic                 valid_s1, last_s1;
	logic [7:0]           data_s1;

	logic [CNT_W-1:0]     cnt_q, nx_cnt;
	logic [15:0]          ether_kind_q, frag_q, tlen_q, ulen_q, aulen_q;
	logic [3:0]           ihl_q, doff_q, adoff_q;
	logic [7:0]           proto_q;
	frame_t               nx;

	frame_t               frm_q;
	logic                 frm_valid_q;

	desc_t [MAX_LAYERS-1:0] list_q, slice_list;
	logic [LIST_W-1:0]    dr_cnt_q, slice_cnt;

	logic                 blocked, adv, in_acc, out_acc, load, cfg_wr;
	logic [POS_W-1:0]     pos, base, r, t, q, qa;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_START_LAYER: prdata = DATA_W'(start_layer_q);
			REG_MAX_LAYERS:  prdata = DATA_W'(max_layers_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_layer_q <= 1'b0;
			max_layers_q  <= ML_W'(MAX_LAYERS);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_START_LAYER: start_layer_q <= pwdata[0];
				REG_MAX_LAYERS:  max_layers_q  <= pwdata[ML_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	assign blocked  = valid_s1 && last_s1 && frm_valid_q;
	assign in_stall = blocked;
	assign in_acc   = in_valid && !in_stall;
	assign adv      = valid_s1 && !blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!blocked)
			valid_s1 <= in_acc;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// header capture
	always_comb begin
		nx.n          = cnt_q;
		nx.ether_kind = ether_kind_q;
		nx.ihl        = ihl_q;
		nx.frag       = frag_q;
		nx.total_len  = tlen_q;
		nx.proto      = proto_q;
		nx.doff       = doff_q;
		nx.ulen       = ulen_q;
		nx.alt_doff   = adoff_q;
		nx.alt_ulen   = aulen_q;
		nx_cnt        = cnt_q;
		pos           = cnt_q[POS_W-1:0];
		base          = start_layer_q ? '0 : POS_W'(ETH_HDR);
		r             = pos - base;
		t             = POS_W'({ihl_q, 2'b00});
		q             = r - t;
		qa            = r - POS_W'(IP_HDR);
		if (int'(cnt_q) < MAX_FRAME_BYTES) begin
			nx_cnt = cnt_q + 1'b1;
			if (!start_layer_q) begin
				if (pos == POS_W'(12)) nx.ether_kind[15:8] = data_s1;
				if (pos == POS_W'(13)) nx.ether_kind[7:0]  = data_s1;
			end
			if (pos >= base) begin
				if (r == POS_W'(0)) nx.ihl             = data_s1[3:0];
				if (r == POS_W'(2)) nx.total_len[15:8] = data_s1;
				if (r == POS_W'(3)) nx.total_len[7:0]  = data_s1;
				if (r == POS_W'(6)) nx.frag[15:8]      = data_s1;
				if (r == POS_W'(7)) nx.frag[7:0]       = data_s1;
				if (r == POS_W'(9)) nx.proto           = data_s1;
				if (r >= t) begin
					if (q == POS_W'(4))  nx.ulen[15:8] = data_s1;
					if (q == POS_W'(5))  nx.ulen[7:0]  = data_s1;
					if (q == POS_W'(12)) nx.doff       = data_s1[7:4];
				end
				if (r >= POS_W'(IP_HDR)) begin
					if (qa == POS_W'(4))  nx.alt_ulen[15:8] = data_s1;
					if (qa == POS_W'(5))  nx.alt_ulen[7:0]  = data_s1;
					if (qa == POS_W'(12)) nx.alt_doff       = data_s1[7:4];
				end
			end
		end
		nx.n = nx_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			ether_kind_q <= '0;
			ihl_q        <= '0;
			frag_q       <= '0;
			tlen_q       <= '0;
			proto_q      <= '0;
			doff_q       <= '0;
			ulen_q       <= '0;
			adoff_q      <= '0;
			aulen_q      <= '0;
		end else if (adv) begin
			if (last_s1) begin
				cnt_q        <= '0;
				ether_kind_q <= '0;
				ihl_q        <= '0;
				frag_q       <= '0;
				tlen_q       <= '0;
				proto_q      <= '0;
				doff_q       <= '0;
				ulen_q       <= '0;
				adoff_q      <= '0;
				aulen_q      <= '0;
			end else begin
				cnt_q        <= nx_cnt;
				ether_kind_q <= nx.ether_kind;
				ihl_q        <= nx.ihl;
				frag_q       <= nx.frag;
				tlen_q       <= nx.total_len;
				proto_q      <= nx.proto;
				doff_q       <= nx.doff;
				ulen_q       <= nx.ulen;
				adoff_q      <= nx.alt_doff;
				aulen_q      <= nx.alt_ulen;
			end
		end
	end

	// frame summary hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			frm_valid_q <= 1'b0;
		else if (adv && last_s1)
			frm_valid_q <= 1'b1;
		else if (load)
			frm_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1)
			frm_q <= nx;
	end

	pls_slicer u_slicer (
		.frm         (frm_q),
		.start_layer (start_layer_q),
		.max_layers  (max_layers_q),
		.list        (slice_list),
		.count       (slice_cnt)
	);

	// descriptor drain
	assign out_valid = dr_cnt_q != '0;
	assign out_acc   = out_valid && !out_stall;
	assign load      = frm_valid_q
		&& (dr_cnt_q == '0 || (dr_cnt_q == LIST_W'(1) && out_acc));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dr_cnt_q <= '0;
		else if (load)
			dr_cnt_q <= slice_cnt;
		else if (out_acc)
			dr_cnt_q <= dr_cnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			list_q <= slice_list;
		end else if (out_acc) begin
			for (int i = 0; i < MAX_LAYERS - 1; i++)
				list_q[i] <= list_q[i+1];
		end
	end

	assign layer_type   = list_q[0].ltype;
	assign layer_offset = list_q[0].offset;
	assign layer_length = list_q[0].length;
	assign damaged      = list_q[0].damaged;
	assign truncated    = list_q[0].truncated;
	assign final_layer  = list_q[0].final_layer;
	assign unsupported  = list_q[0].unsupported;
	assign no_layer     = list_q[0].no_layer;
	assign last_of_run  = dr_cnt_q == LIST_W'(1);

endmodule

>>> hw/rtl/pls_checker.sv
// Port-level checks of the packet layer slicer and their binding to the top level.
module pls_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [2:0]                layer_type,
	input logic [pls_pkg::OFF_W-1:0] layer_offset,
	input logic [pls_pkg::LEN_W-1:0] layer_length,
	input logic                      damaged,
	input logic                      no_layer,
	input logic                      last_of_run
);
	import pls_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(layer_type)
			&& $stable(layer_offset) && $stable(layer_length) && $stable(last_of_run))
		else $error("stalled descriptor changed");

	a_no_layer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_layer |-> last_of_run && layer_type == 3'(LT_ETH)
			&& layer_offset == '0 && layer_length == '0 && !damaged)
		else $error("empty-frame result malformed");

	a_eth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !no_layer && layer_type == 3'(LT_ETH)
			|-> layer_offset == '0 && layer_length == LEN_W'(ETH_HDR))
		else $error("ethernet descriptor malformed");

	a_l4_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (layer_type == 3'(LT_TCP) || layer_type == 3'(LT_UDP)
			|| layer_type == 3'(LT_IP))
			|-> layer_length == LEN_W'(TCP_HDR) || layer_length == LEN_W'(UDP_HDR))
		else $error("header descriptor has wrong length");

endmodule

bind packet_layer_slicer_core pls_checker u_pls_checker (.*);

>>> dv/pls_desc_checker.sv
// Descriptor checker for the packet layer slicer: snoops config, predicts and compares.
`timescale 1ns / 100ps

module pls_desc_checker
	import pls_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	input  logic                pready,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [2:0]          layer_type,
	input  logic [OFF_W-1:0]    layer_offset,
	input  logic [LEN_W-1:0]    layer_length,
	input  logic                damaged,
	input  logic                truncated,
	input  logic                final_layer,
	input  logic                unsupported,
	input  logic                no_layer,
	input  logic                last_of_run,
	output int                  mismatch_count,
	output int                  pending
);

	typedef struct packed {
		desc_t d;
		logic  last_of_run;
	} layer_desc_t;

	layer_desc_t   expected_layers[$];

	logic          cfg_start_layer;
	logic [3:0]    cfg_max_layers;

	int unsigned   byte_cnt;
	logic [15:0]   ether_kind;
	logic [3:0]    ihl;
	logic [15:0]   frag_field;
	logic [15:0]   total_len;
	logic [7:0]    proto;
	logic [3:0]    doff;
	logic [15:0]   ulen;
	logic [3:0]    alt_doff;
	logic [15:0]   alt_ulen;

	desc_t         frame_descs[MAX_LAYERS];
	int            frame_cnt;
	int            frame_cap;

	function automatic void clear_frame();
		byte_cnt   = 0;
		ether_kind = '0;
		ihl        = '0;
		frag_field = '0;
		total_len  = '0;
		proto      = '0;
		doff       = '0;
		ulen       = '0;
		alt_doff   = '0;
		alt_ulen   = '0;
	endfunction

	function automatic void capture_byte(int unsigned pos, logic [7:0] b);
		int unsigned base, r, t, q;
		base = cfg_start_layer ? 0 : ETH_HDR;
		if (base != 0) begin
			if (pos == 12) ether_kind[15:8] = b;
			if (pos == 13) ether_kind[7:0] = b;
		end
		if (pos < base) return;
		r = pos - base;
		if (r == 0) ihl = b[3:0];
		if (r == 2) total_len[15:8] = b;
		if (r == 3) total_len[7:0] = b;
		if (r == 6) frag_field[15:8] = b;
		if (r == 7) frag_field[7:0] = b;
		if (r == 9) proto = b;
		// transport fields follow the options as the IHL says so far
		t = int'(ihl) * 4;
		if (r >= t) begin
			q = r - t;
			if (q == 4) ulen[15:8] = b;
			if (q == 5) ulen[7:0] = b;
			if (q == 12) doff = b[7:4];
		end
		// same fields right after the base header, used when options overrun
		if (r >= IP_HDR) begin
			q = r - IP_HDR;
			if (q == 4) alt_ulen[15:8] = b;
			if (q == 5) alt_ulen[7:0] = b;
			if (q == 12) alt_doff = b[7:4];
		end
	endfunction

	function automatic void add_layer(layer_type_t lt, int unsigned off, int unsigned len,
			logic dmg, logic trunc, logic fin, logic unsup);
		desc_t d;
		if (frame_cnt >= frame_cap) return;
		d.ltype       = lt;
		d.offset      = OFF_W'(off);
		d.length      = LEN_W'(len);
		d.damaged     = dmg;
		d.truncated   = trunc;
		d.final_layer = fin;
		d.unsupported = unsup;
		d.no_layer    = 1'b0;
		frame_descs[frame_cnt] = d;
		frame_cnt++;
	endfunction

	function automatic void slice_frame();
		int unsigned n, base, pk, lim, opt, t, tl, doff_v, ulen_v, to, rem, pay, junk, hl;
		logic dmg, dm, tr, alt;
		n    = byte_cnt;
		base = 0;
		dmg  = 1'b0;
		alt  = 1'b0;
		if (!cfg_start_layer) begin
			if (n < ETH_HDR) return;
			add_layer(LT_ETH, 0, ETH_HDR, 0, 0, 0, 0);
			if (ether_kind != ETHERTYPE_IPV4) return;
			base = ETH_HDR;
		end
		pk = n - base;
		if (pk < IP_HDR) return;
		if (ihl < IHL_MIN) begin
			add_layer(LT_IP, base, IP_HDR, 1, 0, 1, 0);
			return;
		end
		if (frag_field[12:0] != 0) begin
			add_layer(LT_IP, base, IP_HDR, 0, 0, 1, 1);
			return;
		end
		lim = pk;
		if (total_len > pk) dmg = 1'b1;
		else lim = total_len;
		opt = (int'(ihl) - 5) * 4;
		if (opt + IP_HDR > pk) begin
			dmg = 1'b1;
			opt = 0;
			alt = 1'b1;
		end
		add_layer(LT_IP, base, IP_HDR, dmg, 0, 0, 0);
		if (opt != 0) add_layer(LT_IPOPT, base + IP_HDR, opt, 0, 0, 0, 0);
		t      = base + IP_HDR + opt;
		tl     = (lim >= IP_HDR + opt) ? lim - IP_HDR - opt : 0;
		doff_v = alt ? alt_doff : doff;
		ulen_v = alt ? alt_ulen : ulen;
		if (proto == PROTO_TCP) begin
			dm = 1'b0;
			tr = 1'b0;
			if (tl < TCP_HDR) return;
			if (doff_v > 0 && doff_v * 4 > tl) begin
				dm = 1'b1;
				tr = 1'b1;
				doff_v = 0;
			end
			if (doff_v > 0 && doff_v < 5) begin
				dm = 1'b1;
				doff_v = 5;
			end
			if (doff_v > 0) begin
				to  = doff_v * 4 - TCP_HDR;
				rem = tl - doff_v * 4;
			end else begin
				to  = tl - TCP_HDR;
				rem = 0;
			end
			add_layer(LT_TCP, t, TCP_HDR, dm, tr, 0, 0);
			if (to != 0) add_layer(LT_TCPOPT, t + TCP_HDR, to, 0, 0, 0, 0);
			if (rem != 0) add_layer(LT_PAYLOAD, t + TCP_HDR + to, rem, 0, 0, 0, 0);
		end else if (proto == PROTO_UDP) begin
			if (tl < UDP_HDR) return;
			junk = 0;
			if (ulen_v > tl) begin
				add_layer(LT_UDP, t, UDP_HDR, 1, 0, 0, 0);
				pay = tl - UDP_HDR;
			end else begin
				add_layer(LT_UDP, t, UDP_HDR, 0, 0, 0, 0);
				hl   = (ulen_v < UDP_HDR) ? UDP_HDR : ulen_v;
				pay  = hl - UDP_HDR;
				junk = tl - hl;
			end
			if (pay != 0) add_layer(LT_PAYLOAD, t + UDP_HDR, pay, 0, 0, 0, 0);
			if (junk != 0) add_layer(LT_JUNK, t + UDP_HDR + pay, junk, 0, 0, 0, 0);
		end
	endfunction

	function automatic void take_byte(logic [7:0] b, logic last);
		layer_desc_t e;
		int i;
		if (byte_cnt < MAX_FRAME_BYTES) begin
			capture_byte(byte_cnt, b);
			byte_cnt++;
		end
		if (!last) return;
		frame_cap = cfg_max_layers;
		if (frame_cap < 1) frame_cap = 1;
		if (frame_cap > MAX_LAYERS) frame_cap = MAX_LAYERS;
		frame_cnt = 0;
		slice_frame();
		if (frame_cnt == 0) begin
			add_layer(LT_ETH, 0, 0, 0, 0, 0, 0);
			frame_descs[0].no_layer = 1'b1;
		end
		for (i = 0; i < frame_cnt; i++) begin
			e.d           = frame_descs[i];
			e.last_of_run = (i == frame_cnt - 1);
			expected_layers.push_back(e);
		end
		clear_frame();
	endfunction

	function automatic void compare_field(string fname, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic void check_desc();
		layer_desc_t e;
		if (expected_layers.size() == 0) begin
			$error("descriptor with none expected: type %0d offset %0d length %0d",
				layer_type, layer_offset, layer_length);
			mismatch_count++;
			return;
		end
		e = expected_layers.pop_front();
		compare_field("layer_type", e.d.ltype, layer_type);
		compare_field("layer_offset", e.d.offset, layer_offset);
		compare_field("layer_length", e.d.length, layer_length);
		compare_field("damaged", e.d.damaged, damaged);
		compare_field("truncated", e.d.truncated, truncated);
		compare_field("final_layer", e.d.final_layer, final_layer);
		compare_field("unsupported", e.d.unsupported, unsupported);
		compare_field("no_layer", e.d.no_layer, no_layer);
		compare_field("last_of_run", e.last_of_run, last_of_run);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_start_layer = 1'b0;
			cfg_max_layers  = 4'd8;
			clear_frame();
			expected_layers.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_START_LAYER: cfg_start_layer = pwdata[0];
					REG_MAX_LAYERS:  cfg_max_layers  = pwdata[3:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) check_desc();
			if (in_valid && !in_stall) take_byte(data_byte, last_byte);
			pending <= expected_layers.size();
		end
	end

endmodule

>>> dv/tb_packet_layer_slicer_core.sv
// Testbench top for the packet layer slicer: clock, reset, register writes and frame stimulus.
`timescale 1ns / 100ps

module tb_packet_layer_slicer_core;
	import pls_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [ADDR_W-1:0]   paddr     = '0;
	logic [DATA_W-1:0]   pwdata    = '0;
	logic                in_valid  = 1'b0;
	logic [7:0]          data_byte = '0;
	logic                last_byte = 1'b0;
	logic                out_stall = 1'b0;

	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_stall;
	logic                out_valid;
	logic [2:0]          layer_type;
	logic [OFF_W-1:0]    layer_offset;
	logic [LEN_W-1:0]    layer_length;
	logic                damaged;
	logic                truncated;
	logic                final_layer;
	logic                unsupported;
	logic                no_layer;
	logic                last_of_run;

	int                  mismatch_count;
	int                  pending;

	logic [7:0]          frame_buf[$];
	logic                cur_start;
	bit                  in_quiet  = 1'b0;
	bit                  out_quiet = 1'b0;
	int                  bytes_sent;
	int                  frames_sent;
	int                  cycle_cnt;
	int                  stall_hold;

	always #5 clk = ~clk;

	packet_layer_slicer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.layer_type   (layer_type),
		.layer_offset (layer_offset),
		.layer_length (layer_length),
		.damaged      (damaged),
		.truncated    (truncated),
		.final_layer  (final_layer),
		.unsupported  (unsupported),
		.no_layer     (no_layer),
		.last_of_run  (last_of_run)
	);

	pls_desc_checker u_desc_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.layer_type     (layer_type),
		.layer_offset   (layer_offset),
		.layer_length   (layer_length),
		.damaged        (damaged),
		.truncated      (truncated),
		.final_layer    (final_layer),
		.unsupported    (unsupported),
		.no_layer       (no_layer),
		.last_of_run    (last_of_run),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else if (out_quiet) begin
			out_stall <= 1'b0;
		end else begin
			out_stall  <= ($urandom_range(0, 99) < 30);
			stall_hold <= pick_gap();
		end
	end

	task automatic write_reg(input logic [ADDR_W-3:0] reg_idx, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic start, input int max_l);
		write_reg(REG_START_LAYER, start);
		write_reg(REG_MAX_LAYERS, max_l);
		cur_start = start;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// in_valid stays high across back-to-back items; it drops only for a gap
	task automatic send_frame();
		int gap, i;
		for (i = 0; i < frame_buf.size(); i++) begin
			gap = in_quiet ? 0 : pick_gap();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid  <= 1'b1;
			data_byte <= frame_buf[i];
			last_byte <= (i == frame_buf.size() - 1);
			@(posedge clk);
			while (in_stall) @(posedge clk);
		end
		bytes_sent += frame_buf.size();
		frames_sent++;
	endtask

	// tot_len / udp_len of -1 mean consistent with the built frame; cut_len -1 means no cut
	task automatic build_frame(input logic [15:0] etype, input logic [3:0] ihl,
			input int tot_len, input logic [15:0] frag, input logic [7:0] proto,
			input logic [3:0] doff, input int udp_len, input int pay_len,
			input int trail_len, input int cut_len);
		int ip_start, l4;
		logic [15:0] v;
		frame_buf.delete();
		if (!cur_start) begin
			repeat (12) frame_buf.push_back(8'($urandom));
			frame_buf.push_back(etype[15:8]);
			frame_buf.push_back(etype[7:0]);
		end
		ip_start = frame_buf.size();
		frame_buf.push_back({4'h4, ihl});
		frame_buf.push_back(8'($urandom));
		frame_buf.push_back(8'h00);
		frame_buf.push_back(8'h00);
		repeat (2) frame_buf.push_back(8'($urandom));
		frame_buf.push_back(frag[15:8]);
		frame_buf.push_back(frag[7:0]);
		frame_buf.push_back(8'($urandom));
		frame_buf.push_back(proto);
		repeat (10) frame_buf.push_back(8'($urandom));
		if (ihl > IHL_MIN) repeat ((int'(ihl) - 5) * 4) frame_buf.push_back(8'($urandom));
		l4 = frame_buf.size();
		if (proto == PROTO_TCP) begin
			repeat (12) frame_buf.push_back(8'($urandom));
			frame_buf.push_back({doff, 4'($urandom)});
			repeat (7) frame_buf.push_back(8'($urandom));
			if (doff > 5) repeat ((int'(doff) - 5) * 4) frame_buf.push_back(8'($urandom));
		end else if (proto == PROTO_UDP) begin
			repeat (4) frame_buf.push_back(8'($urandom));
			frame_buf.push_back(8'h00);
			frame_buf.push_back(8'h00);
			repeat (2) frame_buf.push_back(8'($urandom));
		end
		repeat (pay_len) frame_buf.push_back(8'($urandom));
		v = (tot_len < 0) ? 16'(frame_buf.size() - ip_start) : 16'(tot_len);
		frame_buf[ip_start + 2] = v[15:8];
		frame_buf[ip_start + 3] = v[7:0];
		if (proto == PROTO_UDP) begin
			v = (udp_len < 0) ? 16'(frame_buf.size() - l4) : 16'(udp_len);
			frame_buf[l4 + 4] = v[15:8];
			frame_buf[l4 + 5] = v[7:0];
		end
		repeat (trail_len) frame_buf.push_back(8'($urandom));
		if (cut_len > 0) while (frame_buf.size() > cut_len) void'(frame_buf.pop_back());
	endtask

	task automatic send_headers(input logic [15:0] etype, input logic [3:0] ihl,
			input int tot_len, input logic [15:0] frag, input logic [7:0] proto,
			input logic [3:0] doff, input int udp_len, input int pay_len,
			input int trail_len, input int cut_len);
		build_frame(etype, ihl, tot_len, frag, proto, doff, udp_len, pay_len, trail_len,
			cut_len);
		send_frame();
	endtask

	task automatic random_frame();
		int r, tot, ul, pay, trail, cut;
		bit clean;
		logic [15:0] et, frag;
		logic [3:0] ihl, doff;
		logic [7:0] proto;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			frame_buf.delete();
			repeat ($urandom_range(1, 70)) frame_buf.push_back(8'($urandom));
			send_frame();
			return;
		end
		clean = ($urandom_range(0, 99) < 70);
		et    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETHERTYPE_IPV4;
		proto = (r < 50) ? PROTO_TCP : (r < 88) ? PROTO_UDP : 8'($urandom);
		if (clean) begin
			ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 8)) : IHL_MIN;
			doff  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 10)) : 4'd5;
			frag  = {3'($urandom), 13'd0};
			tot   = -1;
			ul    = -1;
			trail = 0;
			cut   = -1;
		end else begin
			ihl   = 4'($urandom);
			doff  = 4'($urandom);
			frag  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : {3'($urandom), 13'd0};
			tot   = ($urandom_range(0, 1) == 0) ? -1 :
				($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 120);
			ul    = ($urandom_range(0, 1) == 0) ? -1 :
				($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
			trail = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
			cut   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 60) : -1;
		end
		pay = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
		send_headers(et, ihl, tot, frag, proto, doff, ul, pay, trail, cut);
	endtask

	task automatic run_phase(input logic start, input int max_l);
		int b0, f0;
		set_config(start, max_l);
		b0 = bytes_sent;
		f0 = frames_sent;
		while (bytes_sent - b0 < 70 || frames_sent - f0 < 4) begin
			in_quiet  = ($urandom_range(0, 4) == 0);
			out_quiet = ($urandom_range(0, 4) == 0);
			random_frame();
		end
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_config(1'b0, 8);

		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_TCP, 5, -1, 0, 0, 1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_TCP, 5, -1, 0, 0, 13);
		send_headers(16'h86DD, 5, -1, 0, PROTO_TCP, 5, -1, 4, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_TCP, 5, -1, 0, 0, 33);
		send_headers(ETHERTYPE_IPV4, 4, -1, 0, PROTO_TCP, 5, -1, 0, 0, -1);
		send_headers(ETHERTYPE_IPV4, 0, -1, 0, PROTO_UDP, 5, -1, 4, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 16'h2001, PROTO_TCP, 5, -1, 6, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 16'h4000, PROTO_TCP, 5, -1, 6, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, 1500, 0, PROTO_TCP, 5, -1, 10, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_TCP, 5, -1, 10, 12, -1);
		send_headers(ETHERTYPE_IPV4, 5, 10, 0, PROTO_TCP, 5, -1, 10, 0, -1);
		send_headers(ETHERTYPE_IPV4, 15, -1, 0, PROTO_TCP, 5, -1, 20, 0, 72);
		send_headers(ETHERTYPE_IPV4, 15, -1, 0, PROTO_UDP, 5, -1, 20, 0, 72);
		send_headers(ETHERTYPE_IPV4, 7, -1, 0, PROTO_TCP, 8, -1, 6, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, 8'd1, 5, -1, 12, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_TCP, 15, -1, 0, 0, 74);
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_TCP, 0, -1, 10, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_TCP, 3, -1, 5, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_TCP, 15, -1, 8, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_UDP, 5, 200, 10, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_UDP, 5, 12, 10, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_UDP, 5, 3, 10, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_UDP, 5, -1, 0, 0, -1);
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_UDP, 5, -1, 16, 0, -1);
		// frame longer than the capture limit, sent back to back
		in_quiet = 1'b1;
		send_headers(ETHERTYPE_IPV4, 5, -1, 0, PROTO_TCP, 5, -1, 16400, 0, -1);
		in_quiet = 1'b0;
		wait_idle();

		run_phase(1'b1, 8);
		run_phase(1'b0, 1);
		run_phase(1'b1, 15);
		run_phase(1'b0, 0);
		run_phase(1'b1, 3);
		run_phase(1'b0, 8);
		run_phase(1'b0, 5);

		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/pls_pkg.sv
hw/rtl/pls_slicer.sv
hw/rtl/packet_layer_slicer_core.sv
hw/rtl/pls_checker.sv
dv/pls_desc_checker.sv
dv/tb_packet_layer_slicer_core.sv
